// ===== rtl/ssl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_pkg: shared types and constants
// Field widths, register indexes, controller states, and the command and
// status bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int CHANNELS_DEF  = 16;
  localparam int EXP_DEPTH_DEF = 256;

  localparam int CH_W       = 4;
  localparam int IN_W       = 19;
  localparam int SEC_W      = 20;
  localparam int SHAPE_W    = 16;
  localparam int PERIOD_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int LV_W  = 32;
  localparam int SS_W  = 24;
  localparam int DIR_W = 2;
  localparam int E_W   = 25;

  localparam int DVD_W = 56;
  localparam int DSR_W = 43;

  localparam logic [CFG_IDX_W-1:0] REG_RISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd89478;
  localparam logic [SS_W-1:0]     STEP_RESET   = 24'd2621440;
  localparam logic [SS_W-1:0]     MIN_STEP     = 24'd26;
  localparam logic [SEC_W-1:0]    MIN_SLEW     = 20'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_DECIDE, S_U_START, S_U_WAIT, S_SHAPE, S_KU,
    S_EXP_IDX, S_EXP_TAB, S_EXP_MUL, S_EXP_END, S_KE,
    S_M_START, S_M_WAIT, S_QPROD, S_Q_START, S_Q_WAIT, S_MUL, S_STEP, S_FIN
  } ssl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_EVAL, OP_SHAPE, OP_KU, OP_EXP_IDX, OP_EXP_TAB, OP_EXP_MUL,
    OP_EXP_END, OP_KE, OP_QPROD, OP_MUL, OP_STEP, OP_FIN
  } ssl_op_t;

  typedef enum logic [1:0] {DS_U, DS_M, DS_Q} ssl_dsel_t;

  typedef struct packed {
    logic      load;
    ssl_op_t   op;
    logic      div_start;
    ssl_dsel_t dsel;
    logic      pass;
    logic [1:0] chunk;
  } ssl_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic skip;
    logic shape_zero;
    logic shape_neg;
    logic div_done;
  } ssl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ssl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_ram: generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ssl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ssl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_div: bit-serial restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle and the
// quotient holds until the next start.
// ----------------------------------------------------------------------------
module ssl_div #(
  parameter int DVD_W = 56,
  parameter int DSR_W = 43
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DSR_W:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? DSR_W'(trial - {1'b0, dsr}) : trial[DSR_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ssl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_dp: slew limiter datapath
// Per-voice state memory, shared divider, exponential table and the
// arithmetic steps selected by the controller's command.
// ----------------------------------------------------------------------------
module ssl_dp #(
  parameter int CHANNELS        = ssl_pkg::CHANNELS_DEF,
  parameter int EXP_TABLE_DEPTH = ssl_pkg::EXP_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ssl_pkg::ssl_cmd_t                      cmd,
  output ssl_pkg::ssl_stat_t                     stat,
  input  logic [ssl_pkg::CH_W-1:0]               channel,
  input  logic signed [ssl_pkg::IN_W-1:0]        sample_in,
  input  logic signed [ssl_pkg::IN_W-1:0]        offset_volts,
  input  logic [ssl_pkg::SEC_W-1:0]              slew_seconds,
  input  logic                                   cfg_write,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic [ssl_pkg::CH_W-1:0]               out_channel,
  output logic signed [ssl_pkg::IN_W-1:0]        sample_out
);
  import ssl_pkg::*;

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW    = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int TW    = 18 + IW;
  localparam int RAM_W = LV_W + IN_W + SS_W + DIR_W;
  localparam int ACC_W = 47 + 64;

  typedef logic [E_W-1:0] exp_tab_t [EXP_TABLE_DEPTH+1];

  // exp(-8i/D) in Q1.24: series for exp(-x/8) in Q30, squared three times.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        tab;
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      x    = (64'(i) << 30) / 64'(EXP_TABLE_DEPTH);
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 20; n++) begin
        term = ((term * x) >> 30) / 64'(n);
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      v = 64'(sum);
      for (int j = 0; j < 3; j++) begin
        v = (v * v) >> 30;
      end
      v = (v + 64'd32) >> 6;
      if (v == 0) v = 64'd1;
      tab[i] = E_W'(v);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // Configuration registers.
  logic signed [SHAPE_W-1:0] rise_shape;
  logic signed [SHAPE_W-1:0] fall_shape;
  logic [PERIOD_W-1:0]       sample_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_shape    <= '0;
      fall_shape    <= '0;
      sample_period <= PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RISE:   rise_shape    <= cfg_data[SHAPE_W-1:0];
        REG_FALL:   fall_shape    <= cfg_data[SHAPE_W-1:0];
        REG_PERIOD: sample_period <= cfg_data[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  // Captured item and per-voice state.
  logic [CW-1:0]          addr;
  logic [CH_W-1:0]        ch;
  logic signed [20:0]     target;
  logic [SEC_W-1:0]       sec;
  logic [CHANNELS-1:0]    valid;
  logic                   rd_valid;
  logic [RAM_W-1:0]       rdata;
  logic [RAM_W-1:0]       wdata;
  logic                   ram_we;

  logic signed [LV_W-1:0] lv;
  logic signed [LV_W-1:0] lv_new;
  logic signed [29:0]     tl;
  logic [SS_W-1:0]        ss;
  logic signed [DIR_W-1:0] dir;
  logic [23:0]            aerr;
  logic                   short_r;
  logic                   eq_r;
  logic [14:0]            s_abs;
  logic                   s_neg;
  logic                   s_zero;
  logic [16:0]            u;
  logic [17:0]            ku;
  logic [IW-1:0]          eidx;
  logic [16:0]            efrac;
  logic                   eend;
  logic [E_W-1:0]         ea;
  logic [E_W-1:0]         eb;
  logic [E_W-1:0]         e1;
  logic [E_W-1:0]         e2;
  logic [41:0]            eprod;
  logic [DSR_W-1:0]       kde;
  logic [63:0]            m;
  logic [47:0]            sp_prod;
  logic [ACC_W-1:0]       acc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr   <= CW'(channel);
      ch     <= channel;
      target <= 21'(sample_in) + 21'(offset_volts);
      sec    <= slew_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_valid <= valid[CW'(channel)];
      end
      if (ram_we) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  ssl_ram #(.WIDTH(RAM_W), .DEPTH(CHANNELS)) u_state (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (CW'(channel)),
    .rdata (rdata)
  );

  // Unwritten voices read as their reset state.
  logic signed [LV_W-1:0]  rd_lv;
  logic signed [IN_W-1:0]  rd_last;
  logic [SS_W-1:0]         rd_ss;
  logic signed [DIR_W-1:0] rd_dir;

  assign rd_lv   = rd_valid ? rdata[RAM_W-1 -: LV_W] : '0;
  assign rd_last = rd_valid ? rdata[RAM_W-LV_W-1 -: IN_W] : '0;
  assign rd_ss   = rd_valid ? rdata[DIR_W +: SS_W] : STEP_RESET;
  assign rd_dir  = rd_valid ? rdata[DIR_W-1:0] : '0;

  // Error against the last output and move restart.
  logic signed [21:0]        err;
  logic signed [DIR_W-1:0]   e_sgn;
  logic [21:0]               e_abs;
  logic [23:0]               aerr_c;
  logic                      restart;
  logic signed [29:0]        tl_c;
  logic                      rise_c;
  logic signed [SHAPE_W-1:0] s_sel;
  logic signed [SHAPE_W-1:0] s_cl;
  logic [SHAPE_W-1:0]        s_mag;

  always_comb begin
    err     = 22'(target) - 22'(rd_last);
    e_sgn   = (err > 0) ? 2'sb01 : ((err < 0) ? 2'sb11 : 2'sb00);
    e_abs   = (err < 0) ? 22'(-err) : 22'(err);
    aerr_c  = {e_abs[19:0], 4'b0000};
    restart = (e_sgn != rd_dir) || (aerr_c > rd_ss);
    tl_c    = {target[19:0], 10'b0};
    rise_c  = (tl_c > rd_lv);
    s_sel   = rise_c ? rise_shape : fall_shape;
    if (s_sel > 16'sd16384) begin
      s_cl = 16'sd16384;
    end else if (s_sel < -16'sd16384) begin
      s_cl = -16'sd16384;
    end else begin
      s_cl = s_sel;
    end
    s_mag = (s_cl < 0) ? 16'(-s_cl) : 16'(s_cl);
  end

  // Curve constant: 8|s| when negative, 6s when positive.
  logic [17:0] k;
  logic [17:0] num;
  logic [34:0] kxu;
  logic [17:0] ex;
  logic [TW-1:0] et;

  assign k   = s_neg ? {s_abs, 3'b000} : (18'(s_abs) * 18'd6);
  assign num = 18'd16384 + (k >> 1);
  assign kxu = 35'(k) * 35'(u);
  assign ex  = cmd.pass ? ((ku > 18'd131072) ? 18'd131072 : ku)
                        : ((k > 18'd131072) ? 18'd131072 : k);
  assign et  = TW'(ex) * TW'(EXP_TABLE_DEPTH);

  // Shared divider.
  logic             div_done;
  logic [DVD_W-1:0] quo;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;

  always_comb begin
    case (cmd.dsel)
      DS_U: begin
        dvd = DVD_W'({aerr, 16'b0});
        dsr = DSR_W'(ss);
      end
      DS_M: begin
        if (s_neg) begin
          dvd = DVD_W'({25'h1000000 - e1, 30'b0});
          dsr = kde;
        end else begin
          dvd = DVD_W'({num, 16'b0});
          dsr = DSR_W'(18'd16384 + ku);
        end
      end
      DS_Q: begin
        dvd = DVD_W'(sp_prod);
        dsr = DSR_W'(sec);
      end
      default: begin
        dvd = '0;
        dsr = DSR_W'(1);
      end
    endcase
  end

  ssl_div #(.DVD_W(DVD_W), .DSR_W(DSR_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (quo)
  );

  // Step size and level update.
  logic [E_W-1:0]     ediff;
  logic [62:0]        part;
  logic [84:0]        dq;
  logic [33:0]        delta;
  logic signed [34:0] lv_up;
  logic signed [34:0] lv_dn;
  logic signed [34:0] tl35;
  logic signed [LV_W-1:0] moved;
  logic signed [LV_W-1:0] y;
  logic signed [LV_W-1:0] yr;

  always_comb begin
    ediff = (eb > ea) ? '0 : (ea - eb);
    part  = 63'(quo[46:0]) * 63'(m[16*cmd.chunk +: 16]);
    dq    = acc[ACC_W-1:26];
    delta = (|dq[84:33]) ? 34'h200000000 : dq[33:0];
    tl35  = 35'(tl);
    lv_up = 35'(lv) + $signed({1'b0, delta});
    lv_dn = 35'(lv) - $signed({1'b0, delta});
    if (tl35 > 35'(lv)) begin
      moved = (lv_up > tl35) ? LV_W'(tl) : LV_W'(lv_up);
    end else begin
      moved = (lv_dn < tl35) ? LV_W'(tl) : LV_W'(lv_dn);
    end
    if (lv_new > 32'sd201326592) begin
      y = 32'sd201326592;
    end else if (lv_new < -32'sd201326592) begin
      y = -32'sd201326592;
    end else begin
      y = lv_new;
    end
    yr = (y + 32'sd512) >>> 10;
  end

  assign ram_we = (cmd.op == OP_FIN);
  assign wdata  = {lv_new, yr[IN_W-1:0], ss, dir};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_EVAL: begin
        lv      <= rd_lv;
        tl      <= tl_c;
        aerr    <= aerr_c;
        ss      <= restart ? ((aerr_c > MIN_STEP) ? aerr_c : MIN_STEP) : rd_ss;
        dir     <= restart ? e_sgn : rd_dir;
        short_r <= (sec <= MIN_SLEW);
        eq_r    <= (tl_c == rd_lv);
        s_abs   <= s_mag[14:0];
        s_neg   <= (s_cl < 0);
        s_zero  <= (s_cl == 0);
      end
      OP_SHAPE: u <= (quo > DVD_W'(65536)) ? 17'd65536 : quo[16:0];
      OP_KU: ku <= kxu[33:16];
      OP_EXP_IDX: begin
        eidx  <= IW'(et >> 17);
        efrac <= et[16:0];
        eend  <= ((et >> 17) >= TW'(EXP_TABLE_DEPTH));
      end
      OP_EXP_TAB: begin
        ea <= EXP_TAB[eend ? IW'(EXP_TABLE_DEPTH) : eidx];
        eb <= EXP_TAB[eend ? IW'(EXP_TABLE_DEPTH) : IW'(eidx + 1'b1)];
      end
      OP_EXP_MUL: eprod <= 42'(ediff) * 42'(efrac);
      OP_EXP_END: begin
        if (cmd.pass) begin
          e2 <= ea - E_W'(eprod >> 17);
        end else begin
          e1 <= ea - E_W'(eprod >> 17);
        end
      end
      OP_KE: kde <= DSR_W'(k) * DSR_W'(e2);
      OP_QPROD: begin
        if (s_zero) begin
          m <= 64'd65536;
        end else begin
          m <= (quo < DVD_W'(7)) ? 64'd7 : 64'(quo);
        end
        sp_prod <= 48'(ss) * 48'(sample_period);
      end
      OP_MUL: begin
        if (cmd.chunk == 2'd0) begin
          acc <= ACC_W'(part);
        end else begin
          acc <= acc + (ACC_W'(part) << {cmd.chunk, 4'b0000});
        end
      end
      OP_STEP: lv_new <= short_r ? LV_W'(tl) : (eq_r ? lv : moved);
      OP_FIN: begin
        out_channel <= ch;
        sample_out  <= yr[IN_W-1:0];
      end
      default: ;
    endcase
  end

  assign stat.ch_ok      = (32'(channel) < CHANNELS);
  assign stat.skip       = short_r || eq_r;
  assign stat.shape_zero = s_zero;
  assign stat.shape_neg  = s_neg;
  assign stat.div_done   = div_done;

endmodule
`default_nettype wire

// ===== rtl/ssl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_ctrl: slew limiter controller
// Sequences one transaction through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module ssl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ssl_pkg::ssl_cmd_t   cmd,
  input  ssl_pkg::ssl_stat_t  stat
);
  import ssl_pkg::*;

  ssl_state_t state;
  ssl_state_t state_next;
  logic       pass;
  logic       pass_next;
  logic [1:0] chunk;
  logic [1:0] chunk_next;
  logic       out_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= 1'b0;
      chunk     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      chunk <= chunk_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    pass_next     = pass;
    chunk_next    = chunk;
    out_set       = 1'b0;
    in_ready      = (state == S_IDLE);
    cmd.load      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    cmd.dsel      = DS_U;
    cmd.pass      = pass;
    cmd.chunk     = chunk;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && stat.ch_ok) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.op     = OP_EVAL;
        pass_next  = 1'b0;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.skip) begin
          state_next = S_STEP;
        end else if (stat.shape_zero) begin
          state_next = S_QPROD;
        end else begin
          state_next = S_U_START;
        end
      end
      S_U_START: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = DS_U;
        state_next    = S_U_WAIT;
      end
      S_U_WAIT: begin
        if (stat.div_done) begin
          state_next = S_SHAPE;
        end
      end
      S_SHAPE: begin
        cmd.op     = OP_SHAPE;
        state_next = S_KU;
      end
      S_KU: begin
        cmd.op     = OP_KU;
        state_next = stat.shape_neg ? S_EXP_IDX : S_M_START;
      end
      S_EXP_IDX: begin
        cmd.op     = OP_EXP_IDX;
        state_next = S_EXP_TAB;
      end
      S_EXP_TAB: begin
        cmd.op     = OP_EXP_TAB;
        state_next = S_EXP_MUL;
      end
      S_EXP_MUL: begin
        cmd.op     = OP_EXP_MUL;
        state_next = S_EXP_END;
      end
      S_EXP_END: begin
        cmd.op = OP_EXP_END;
        if (pass) begin
          state_next = S_KE;
        end else begin
          pass_next  = 1'b1;
          state_next = S_EXP_IDX;
        end
      end
      S_KE: begin
        cmd.op     = OP_KE;
        state_next = S_M_START;
      end
      S_M_START: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = DS_M;
        state_next    = S_M_WAIT;
      end
      S_M_WAIT: begin
        cmd.dsel = DS_M;
        if (stat.div_done) begin
          state_next = S_QPROD;
        end
      end
      S_QPROD: begin
        cmd.op     = OP_QPROD;
        state_next = S_Q_START;
      end
      S_Q_START: begin
        cmd.div_start = 1'b1;
        cmd.dsel      = DS_Q;
        state_next    = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        cmd.dsel   = DS_Q;
        chunk_next = '0;
        if (stat.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (chunk == 2'd3) begin
          state_next = S_STEP;
        end else begin
          chunk_next = chunk + 2'd1;
        end
      end
      S_STEP: begin
        cmd.op     = OP_STEP;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_FIN;
          out_set    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/shaped_slew_limiter_offset_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shaped_slew_limiter_offset_unit: multi-voice shaped slew limiter
// Adds an offset to each voice's input and slews the voice's level toward
// that target with a shaped rise and fall rate, clamped to +-12 V.
// ----------------------------------------------------------------------------
// Each input transaction carries one voice's sample, offset and slew time and
// yields one output transaction with the slewed sample of that voice; a
// transaction whose channel is at or above CHANNELS is accepted and dropped.
// The block handles one transaction at a time. Its latency is set by the
// shared bit-serial divider: a voice that jumps (slew time at or below
// 1e-4 s) or already sits at its target skips the divider, a linear shape
// divides once, and a positive or negative shape divides three times; a
// negative shape also runs the exponential table twice. A transaction may
// also wait for the output register to be taken. A new transaction is accepted
// while the last result is still waiting. Configuration writes are taken at
// any time but are meant to happen only while the block is idle. Per-voice
// state sits in a small RAM; voices not yet written read as their reset state.
module shaped_slew_limiter_offset_unit
  import ssl_pkg::*;
#(
  parameter int CHANNELS        = CHANNELS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ssl_pkg::CH_W-1:0]            channel,
  input  logic signed [ssl_pkg::IN_W-1:0]     sample_in,
  input  logic signed [ssl_pkg::IN_W-1:0]     offset_volts,
  input  logic [ssl_pkg::SEC_W-1:0]           slew_seconds,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ssl_pkg::CH_W-1:0]            out_channel,
  output logic signed [ssl_pkg::IN_W-1:0]     sample_out,
  input  logic                                cfg_write,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ssl_cmd_t  cmd;
  ssl_stat_t stat;

  // The controller walks the states and issues one datapath command a cycle.
  ssl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds configuration, voice state and all arithmetic.
  ssl_dp #(
    .CHANNELS        (CHANNELS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .channel      (channel),
    .sample_in    (sample_in),
    .offset_volts (offset_volts),
    .slew_seconds (slew_seconds),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_channel  (out_channel),
    .sample_out   (sample_out)
  );

endmodule
`default_nettype wire
